[rtl/core/start_stop_time_histogrammer_core_macros.svh]
// ----------------------------------------------------------------------------
// start_stop_time_histogrammer_core_macros
// assertion macros of the histogrammer checker
// ----------------------------------------------------------------------------
`ifndef START_STOP_TIME_HISTOGRAMMER_CORE_MACROS_SVH
`define START_STOP_TIME_HISTOGRAMMER_CORE_MACROS_SVH

// checked only out of reset
`define SSTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SSTH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/ssth_pkg.sv]
// ----------------------------------------------------------------------------
// ssth_pkg
// types and constants of the start/stop time histogrammer
// ----------------------------------------------------------------------------
`default_nettype none

package ssth_pkg;

  localparam int TIME_BITS         = 48;
  localparam int DEF_HIST_BINS     = 128;
  localparam int DEF_MAX_PENDING   = 16;
  localparam int DEF_COUNT_BITS    = 32;
  localparam int CFG_DATA_BITS     = 8;

  localparam logic [2:0] PAT_START = 3'b100;
  localparam logic [2:0] PAT_STOP1 = 3'b010;
  localparam logic [2:0] PAT_STOP2 = 3'b001;

  typedef enum logic [1:0] {
    CMD_EVENT    = 2'd0,
    CMD_READ_BIN = 2'd1,
    CMD_READ_CNT = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FEW_STARTS = 2'd1,
    ST_NO_STOP    = 2'd2,
    ST_LOST       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_S1_SHIFT = 2'd0,
    CFG_S1_COUNT = 2'd1,
    CFG_S2_SHIFT = 2'd2,
    CFG_S2_COUNT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_READ_BIN = 3'd2,
    OP_READ_CNT = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  typedef struct packed {
    cmd_e                  command;
    logic [TIME_BITS-1:0]  event_time;
    logic                  start_bit;
    logic                  stop1_bit;
    logic                  stop2_bit;
    logic                  stop_select;
    logic [6:0]            bin_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] bin_value;
    logic [31:0] matched_starts;
    logic [31:0] stops_used;
    logic [31:0] overflow_hits;
    status_e     status;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    logic [TIME_BITS-1:0] t;
    logic                 ch;
    logic [6:0]           bin;
  } q_item_t;

  typedef struct packed {
    logic [3:0] s1_shift;
    logic [7:0] s1_count;
    logic [3:0] s2_shift;
    logic [7:0] s2_count;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/ssth_front.sv]
// ----------------------------------------------------------------------------
// ssth_front
// classifies incoming beats and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module ssth_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssth_pkg::in_item_t in_data_i,
  output logic              q_valid_o,
  output ssth_pkg::q_item_t q_item_o,
  input  logic              q_pop_i
);
  import ssth_pkg::*;

  q_item_t    fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  q_item_t    item;
  logic       keep;
  logic       push;

  always_comb begin
    item.t   = in_data_i.event_time;
    item.ch  = in_data_i.stop_select;
    item.bin = in_data_i.bin_index;
    item.op  = OP_START;
    keep     = 1'b1;
    unique case (in_data_i.command)
      CMD_EVENT: begin
        priority case ({in_data_i.start_bit, in_data_i.stop1_bit, in_data_i.stop2_bit})
          PAT_START: item.op = OP_START;
          PAT_STOP1: begin
            item.op = OP_STOP;
            item.ch = 1'b0;
          end
          PAT_STOP2: begin
            item.op = OP_STOP;
            item.ch = 1'b1;
          end
          default: keep = 1'b0;
        endcase
      end
      CMD_READ_BIN: item.op = OP_READ_BIN;
      CMD_READ_CNT: item.op = OP_READ_CNT;
      CMD_CLEAR:    item.op = OP_CLEAR;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o && keep;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (q_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

`default_nettype wire

[rtl/core/ssth_back.sv]
// ----------------------------------------------------------------------------
// ssth_back
// sequencer that bins stops, commits pending bins, answers reads and clears
// ----------------------------------------------------------------------------
`default_nettype none

module ssth_back #(
  parameter int HIST_BINS   = ssth_pkg::DEF_HIST_BINS,
  parameter int MAX_PENDING = ssth_pkg::DEF_MAX_PENDING,
  parameter int COUNT_BITS  = ssth_pkg::DEF_COUNT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssth_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  ssth_pkg::q_item_t   q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssth_pkg::out_item_t out_data_o
);
  import ssth_pkg::*;

  localparam int HB_W   = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
  localparam int HA     = HB_W + 1;
  localparam int HDEPTH = 2 ** HA;
  localparam int PW     = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int PA     = PW + 1;
  localparam int PDEPTH = 2 ** PA;
  localparam int FW     = $clog2(MAX_PENDING + 1);
  localparam int CW     = COUNT_BITS;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_STOP, S_CRD, S_CHRD, S_CHWR, S_RDOUT
  } state_e;

  state_e               state_q;
  logic [HA-1:0]        clr_q;
  q_item_t              cur_q;
  logic [TIME_BITS-1:0] diff_q;
  logic                 lt_q;
  logic                 cc_q;
  logic [FW-1:0]        k_q;
  logic [TIME_BITS-1:0] last_q;
  logic [1:0]           starts_q;
  logic [FW-1:0]        fill_q    [2];
  logic [CW-1:0]        matched_q [2];
  logic [CW-1:0]        stops_q   [2];
  logic [CW-1:0]        ovf_q     [2];
  logic [1:0]           seen_q;
  logic [1:0]           lost_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic [CW-1:0] hist_mem [HDEPTH];
  logic [CW-1:0] hist_rd_q;
  logic [7:0]    pend_mem [PDEPTH];
  logic [7:0]    pend_rd_q;

  logic          hist_re, hist_we, pend_re, pend_we;
  logic [HA-1:0] hist_ra, hist_wa;
  logic [CW-1:0] hist_wd;
  logic [PA-1:0] pend_ra, pend_wa;
  logic [7:0]    pend_wd;
  logic [7:0]    cnt_sel;
  logic          in_range;
  logic [TIME_BITS-1:0] shifted;
  logic          stop_ok;
  logic          bin_ok;
  status_e       status;

  function automatic logic [CW-1:0] sinc(logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + CW'(1);
  endfunction

  function automatic logic [31:0] osat(logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  always_comb begin
    cnt_sel  = cc_q ? cfg_i.s2_count : cfg_i.s1_count;
    in_range = (pend_rd_q < cnt_sel) && (32'(pend_rd_q) < HIST_BINS);
    shifted  = diff_q >> (cur_q.ch ? cfg_i.s2_shift : cfg_i.s1_shift);
    stop_ok  = (starts_q != 2'd0) && !lt_q && (32'(fill_q[cur_q.ch]) < MAX_PENDING);
    bin_ok   = (cur_q.op == OP_READ_BIN) && (32'(cur_q.bin) < HIST_BINS);
    q_pop_o  = (state_q == S_IDLE) && q_valid_i;

    hist_re = 1'b0;
    hist_ra = {q_item_i.ch, HB_W'(q_item_i.bin)};
    if (q_pop_o && q_item_i.op == OP_READ_BIN) begin
      hist_re = 1'b1;
    end
    if (state_q == S_CHRD && in_range) begin
      hist_re = 1'b1;
      hist_ra = {cc_q, HB_W'(pend_rd_q)};
    end

    hist_we = 1'b0;
    hist_wa = {cc_q, HB_W'(pend_rd_q)};
    hist_wd = sinc(hist_rd_q);
    if (state_q == S_CLR) begin
      hist_we = 1'b1;
      hist_wa = clr_q;
      hist_wd = '0;
    end else if (state_q == S_CHWR) begin
      hist_we = 1'b1;
    end

    pend_re = (state_q == S_CRD) && (k_q != fill_q[cc_q]);
    pend_ra = {cc_q, k_q[PW-1:0]};
    pend_we = (state_q == S_STOP) && stop_ok;
    pend_wa = {cur_q.ch, fill_q[cur_q.ch][PW-1:0]};
    pend_wd = (|shifted[TIME_BITS-1:8]) ? 8'hFF : shifted[7:0];

    if (starts_q != 2'd2) begin
      status = ST_FEW_STARTS;
    end else if (!seen_q[cur_q.ch]) begin
      status = ST_NO_STOP;
    end else if (lost_q[cur_q.ch]) begin
      status = ST_LOST;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (hist_re) begin
      hist_rd_q <= hist_mem[hist_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    if (pend_re) begin
      pend_rd_q <= pend_mem[pend_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      cur_q       <= '0;
      diff_q      <= '0;
      lt_q        <= 1'b0;
      cc_q        <= 1'b0;
      k_q         <= '0;
      last_q      <= '0;
      starts_q    <= '0;
      fill_q      <= '{default: '0};
      matched_q   <= '{default: '0};
      stops_q     <= '{default: '0};
      ovf_q       <= '{default: '0};
      seen_q      <= '0;
      lost_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_RDOUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + HA'(1);
          if (clr_q == {HA{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            cur_q  <= q_item_i;
            diff_q <= q_item_i.t - last_q;
            lt_q   <= q_item_i.t < last_q;
            cc_q   <= 1'b0;
            k_q    <= '0;
            unique case (q_item_i.op)
              OP_START: state_q <= S_CRD;
              OP_STOP:  state_q <= S_STOP;
              OP_READ_BIN, OP_READ_CNT: state_q <= S_RDOUT;
              OP_CLEAR: begin
                clr_q     <= '0;
                last_q    <= '0;
                starts_q  <= '0;
                fill_q    <= '{default: '0};
                matched_q <= '{default: '0};
                stops_q   <= '{default: '0};
                ovf_q     <= '{default: '0};
                seen_q    <= '0;
                lost_q    <= '0;
                state_q   <= S_CLR;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_STOP: begin
          seen_q[cur_q.ch] <= 1'b1;
          if (starts_q != 2'd0 && !lt_q) begin
            if (stop_ok) begin
              fill_q[cur_q.ch] <= fill_q[cur_q.ch] + FW'(1);
            end else begin
              lost_q[cur_q.ch] <= 1'b1;
            end
          end
          state_q <= S_IDLE;
        end
        S_CRD: begin
          if (k_q == fill_q[cc_q]) begin
            if (fill_q[cc_q] != '0) begin
              matched_q[cc_q] <= sinc(matched_q[cc_q]);
            end
            fill_q[cc_q] <= '0;
            k_q          <= '0;
            if (cc_q) begin
              last_q <= cur_q.t;
              if (starts_q != 2'd2) begin
                starts_q <= starts_q + 2'd1;
              end
              state_q <= S_IDLE;
            end else begin
              cc_q <= 1'b1;
            end
          end else begin
            state_q <= S_CHRD;
          end
        end
        S_CHRD: begin
          if (in_range) begin
            state_q <= S_CHWR;
          end else begin
            ovf_q[cc_q]   <= sinc(ovf_q[cc_q]);
            stops_q[cc_q] <= sinc(stops_q[cc_q]);
            k_q           <= k_q + FW'(1);
            state_q       <= S_CRD;
          end
        end
        S_CHWR: begin
          stops_q[cc_q] <= sinc(stops_q[cc_q]);
          k_q           <= k_q + FW'(1);
          state_q       <= S_CRD;
        end
        S_RDOUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            out_q.bin_value      <= bin_ok ? osat(hist_rd_q) : 32'd0;
            out_q.matched_starts <= osat(matched_q[cur_q.ch]);
            out_q.stops_used     <= osat(stops_q[cur_q.ch]);
            out_q.overflow_hits  <= osat(ovf_q[cur_q.ch]);
            out_q.status         <= status;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/core/start_stop_time_histogrammer_core.sv]
// ----------------------------------------------------------------------------
// start_stop_time_histogrammer_core
// Start/stop time histogrammer. Each item is taken by the front end;
// ignored events end there. In the back end a stop passes through S_STOP, a
// read through S_RDOUT, and a start walks the pending stops of both channels
// in S_CRD, each stop read in S_CHRD and, if binned, written back in S_CHWR,
// since each commit is a read-modify-write on the histogram memory. After
// reset and after a clear all the histogram memory is swept to zero, one
// entry a cycle, all 2 * 2**clog2(HIST_BINS) entries (256 by default); items
// wait in the two-entry queue meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module start_stop_time_histogrammer_core #(
  parameter int HIST_BINS   = ssth_pkg::DEF_HIST_BINS,
  parameter int MAX_PENDING = ssth_pkg::DEF_MAX_PENDING,
  parameter int COUNT_BITS  = ssth_pkg::DEF_COUNT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssth_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssth_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [ssth_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import ssth_pkg::*;

  cfg_t    cfg_q;
  logic    q_valid, q_pop;
  q_item_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.s1_shift <= 4'd3;
      cfg_q.s1_count <= 8'd100;
      cfg_q.s2_shift <= 4'd4;
      cfg_q.s2_count <= 8'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_S1_SHIFT: cfg_q.s1_shift <= cfg_data_i[3:0];
        CFG_S1_COUNT: cfg_q.s1_count <= cfg_data_i;
        CFG_S2_SHIFT: cfg_q.s2_shift <= cfg_data_i[3:0];
        CFG_S2_COUNT: cfg_q.s2_count <= cfg_data_i;
      endcase
    end
  end

  ssth_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  ssth_back #(
    .HIST_BINS   (HIST_BINS),
    .MAX_PENDING (MAX_PENDING),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/core/ssth_checker.sv]
// ----------------------------------------------------------------------------
// ssth_checker
// port-level checks of the histogrammer core
// ----------------------------------------------------------------------------
`default_nettype none

`include "start_stop_time_histogrammer_core_macros.svh"

module ssth_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ssth_pkg::out_item_t out_data_i
);
  import ssth_pkg::*;

  `SSTH_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "result beat changed while stalled")
  `SSTH_ASSERT(a_few_starts, out_valid_i && out_data_i.status == ST_FEW_STARTS |-> out_data_i.matched_starts == 32'd0 && out_data_i.stops_used == 32'd0 && out_data_i.bin_value == 32'd0, "counts without two starts")
  `SSTH_ASSERT(a_no_stop, out_valid_i && out_data_i.status == ST_NO_STOP |-> out_data_i.stops_used == 32'd0 && out_data_i.overflow_hits == 32'd0, "committed stops on a channel with no stop")
  `SSTH_ASSERT(a_count_order, out_valid_i |-> out_data_i.stops_used >= out_data_i.matched_starts && out_data_i.stops_used >= out_data_i.overflow_hits, "counter relation broken")

endmodule

bind start_stop_time_histogrammer_core ssth_checker u_ssth_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
